### sv/srfo_pkg.sv
// Shared types and constants for the section address to file offset translator.
`default_nettype none

package srfo_pkg;

    // Field widths of the item and result formats.
    localparam int ADDR_W        = 32;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int IN_TDATA_W    = 104;
    localparam int OUT_TDATA_W   = 32;

    // Default table depth.
    localparam int SECTIONS_DEF  = 64;

    // Offset reported when no section covers the query.
    localparam logic [ADDR_W-1:0] NOT_FOUND_OFFSET = {ADDR_W{1'b1}};

    // Item kinds carried on the input tuser.
    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    // Query token that walks down the row of section cells.
    typedef struct packed {
        logic              valid;
        logic              has_pick;
        logic              done;
        logic [ADDR_W-1:0] query;
        logic [ADDR_W-1:0] pick_start;
        logic [ADDR_W-1:0] pick_base;
    } srfo_token_t;

endpackage

`default_nettype wire

### sv/srfo_cell.sv
// One section cell: holds one table entry and refines a passing query token.
`default_nettype none

module srfo_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       active,
    input  wire logic                       wr_en,
    input  wire logic [srfo_pkg::ADDR_W-1:0] wr_start,
    input  wire logic [srfo_pkg::ADDR_W-1:0] wr_base,
    input  wire srfo_pkg::srfo_token_t      token_in,
    output srfo_pkg::srfo_token_t           token_out
);
    import srfo_pkg::*;

    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] base_reg;
    srfo_token_t       token_reg;
    srfo_token_t       token_next;

    // Table entry storage, written by load items.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_start;
            base_reg  <= wr_base;
        end
    end

    // Search step: a start above the query ends the scan on the previous pick if there is one,
    // otherwise this section becomes the pick and a start at or above the query ends the scan.
    always_comb
    begin
        token_next = token_in;
        if (token_in.valid && active && !token_in.done)
        begin
            if ((start_reg > token_in.query) && token_in.has_pick)
            begin
                token_next.done = 1'b1;
            end
            else
            begin
                token_next.pick_start = start_reg;
                token_next.pick_base  = base_reg;
                token_next.has_pick   = 1'b1;
                token_next.done       = (start_reg >= token_in.query);
            end
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (advance)
        begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule

`default_nettype wire

### sv/section_rva_to_file_offset.sv
// A translate item passes through the registered section cells, then the output register.
// One translate item per cycle unless the output stalls; a query moves one cell per advance.
// A load item waits until no translate item is still in the cell row.
// Reset clears the section count, the token registers and the output valid bit;
// the section table itself is undefined until loaded.
`default_nettype none

module section_rva_to_file_offset #(
    parameter int MAX_SECTIONS = srfo_pkg::SECTIONS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration: section_count.
    input  wire logic                            cfg_we,
    input  wire logic [srfo_pkg::COUNT_W-1:0]    cfg_wdata,
    // Input items.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: entry_index[5:0], entry_start[37:6], entry_file_base[69:38],
    // query_address[101:70], zero fill[103:102].
    input  wire logic [srfo_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[0].
    input  wire logic                            s_tuser,
    // Result items.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: file_offset[31:0].
    output logic [srfo_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: found[0].
    output logic                                 m_tuser
);
    import srfo_pkg::*;

    logic [COUNT_W-1:0]    count_reg;
    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     offset_reg;
    logic                  found_reg;

    srfo_token_t           head_token;
    srfo_token_t           chain [MAX_SECTIONS+1];
    logic [MAX_SECTIONS-1:0] busy_vec;
    logic                  busy;
    logic                  advance;
    logic                  in_accept;
    logic                  load_accept;

    logic [INDEX_W-1:0]    in_index;
    logic [ADDR_W-1:0]     in_start;
    logic [ADDR_W-1:0]     in_base;
    logic [ADDR_W-1:0]     in_query;

    srfo_token_t           last_token;
    logic                  res_found;
    logic [ADDR_W-1:0]     res_offset;

    // Unpack the input item.
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_start = s_tdata[INDEX_W+ADDR_W-1:INDEX_W];
    assign in_base  = s_tdata[INDEX_W+2*ADDR_W-1:INDEX_W+ADDR_W];
    assign in_query = s_tdata[INDEX_W+3*ADDR_W-1:INDEX_W+2*ADDR_W];

    // Section count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // The row moves whenever the output register is free or being emptied.
    // A load waits until no query token is held in any cell.
    assign advance     = !m_valid_reg || m_tready;
    assign busy        = |busy_vec;
    assign s_tready    = advance && ((s_tuser == REQ_TRANSLATE) || !busy);
    assign in_accept   = s_tvalid && s_tready;
    assign load_accept = in_accept && (s_tuser == REQ_LOAD);

    // Token entering the first cell.
    always_comb
    begin
        head_token       = '0;
        head_token.valid = in_accept && (s_tuser == REQ_TRANSLATE);
        head_token.query = in_query;
    end

    assign chain[0] = head_token;

    // Row of section cells.
    for (genvar k = 0; k < MAX_SECTIONS; k++)
    begin : g_cell
        srfo_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .active    (32'(count_reg) > k),
            .wr_en     (load_accept && (32'(in_index) == k)),
            .wr_start  (in_start),
            .wr_base   (in_base),
            .token_in  (chain[k]),
            .token_out (chain[k+1])
        );
        assign busy_vec[k] = chain[k+1].valid;
    end

    // Final check and offset arithmetic on the token leaving the row.
    assign last_token = chain[MAX_SECTIONS];

    always_comb
    begin
        res_found  = last_token.has_pick && !(last_token.pick_start > last_token.query);
        res_offset = NOT_FOUND_OFFSET;
        if (res_found)
        begin
            res_offset = last_token.pick_base + (last_token.query - last_token.pick_start);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= last_token.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            offset_reg <= res_offset;
            found_reg  <= res_found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = offset_reg;
    assign m_tuser  = found_reg;

    // A load item never overtakes a query still in the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |-> !busy)
        else $error("load accepted while a query is in the cell row");

    // A not-found result carries the all-ones offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == NOT_FOUND_OFFSET))
        else $error("not-found result with a wrong offset");

    // With nothing in flight and nothing accepted, no result can appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !m_tvalid && !in_accept) |=> !m_tvalid)
        else $error("result without a query in flight");

endmodule

`default_nettype wire
